>>> rtl/scanline_color_blob_segmenter_macros.svh
// Assertion helpers for the scan-line blob segmenter.
// Each macro checks an implication on the rising clock edge, off while reset is high.
`ifndef SCANLINE_COLOR_BLOB_SEGMENTER_MACROS_SVH
`define SCANLINE_COLOR_BLOB_SEGMENTER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SCBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define SCBS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SCBS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SCBS_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/scbs_pkg.sv
`timescale 1ns / 1ps
package scbs_pkg;

  localparam int COLOR_W    = 24;
  localparam int RANGE_W    = 16;
  localparam int SUM_W      = 24;
  localparam int ROWS_W     = 9;
  localparam int RPR_W      = 16;
  localparam int FCOUNT_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int COL_OUT_W  = 8;
  localparam int MEAN_W     = 16;

  localparam int MAX_COLUMNS_DEF  = 256;
  localparam int FILTER_SLOTS_DEF = 4;

  localparam logic [SUM_W-1:0]  SUM_MAX        = 24'hFFFFFF;
  localparam logic [MEAN_W-1:0] HALF_HEIGHT_MM = 16'd300;

  localparam logic [ROWS_W-1:0] COLUMNS_RST = 9'd80;
  localparam logic [ROWS_W-1:0] ROWS_RST    = 9'd60;
  localparam logic [RPR_W-1:0]  RPR_RST     = 16'd14668;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_COUNT    = 3'd0,
    REG_FILTER_COLOR_A  = 3'd1,
    REG_FILTER_COLOR_B  = 3'd2,
    REG_FILTER_COLOR_C  = 3'd3,
    REG_FILTER_COLOR_D  = 3'd4,
    REG_COLUMNS_IN_USE  = 3'd5,
    REG_ROWS_IN_USE     = 3'd6,
    REG_ROWS_PER_RADIAN = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [ROWS_W-1:0] rows_in_use;
    logic [RPR_W-1:0]  rows_per_radian;
  } geo_cfg_t;

  typedef struct packed {
    logic                 done;
    logic [MEAN_W-1:0]    mean;
    logic [COL_OUT_W-1:0] top_row;
    logic [ROWS_W-1:0]    bottom_row;
  } geo_res_t;

endpackage

>>> rtl/scbs_if.sv
`timescale 1ns / 1ps
// Sample channel: one scan-line sample per word.
interface scbs_sample_if;
  import scbs_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [COLOR_W-1:0] sample_color;
  logic [RANGE_W-1:0] sample_range_mm;
  logic               end_of_scan;

  modport source (output valid, hit, sample_color, sample_range_mm, end_of_scan,
                  input ready);
  modport sink (input valid, hit, sample_color, sample_range_mm, end_of_scan,
                output ready);
endinterface

// Blob channel: one result per word.
interface scbs_blob_if;
  import scbs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 blob_valid;
  logic [COLOR_W-1:0]   blob_color;
  logic [COL_OUT_W-1:0] left_column;
  logic [COL_OUT_W-1:0] right_column;
  logic [COL_OUT_W-1:0] top_row;
  logic [ROWS_W-1:0]    bottom_row;
  logic [MEAN_W-1:0]    mean_range_mm;
  logic                 scan_done;

  modport source (output valid, blob_valid, blob_color, left_column, right_column,
                  top_row, bottom_row, mean_range_mm, scan_done, input ready);
  modport sink (input valid, blob_valid, blob_color, left_column, right_column,
                top_row, bottom_row, mean_range_mm, scan_done, output ready);
endinterface

>>> rtl/scanline_color_blob_segmenter.sv
`timescale 1ns / 1ps
`include "scanline_color_blob_segmenter_macros.svh"
// Scan-line color blob segmenter. Samples arrive one word at a time; consecutive
// hit samples of one exact color form a run, and the sample that breaks a run is
// dropped. A run that closes and passes the color filter yields one blob word
// with its mirrored column span, mean range and top/bottom rows; every
// end-of-scan sample yields a word with scan_done set (blob fields zero if no
// blob closes on it). A sample that launches no blob does not hold off the next
// one unless an output word cannot leave. A blob holds off further samples
// while the geometry engine runs: the mean division, then one arctangent pass
// when the mean range is at least 300 mm and two otherwise, each of at most 65
// series terms. The series loop, run bit by bit on one shift-add accumulator
// and one restoring divider, takes most of that time. Results leave through
// an output register; no clearing pass is needed after reset.
module scanline_color_blob_segmenter #(
  parameter int MAX_COLUMNS  = scbs_pkg::MAX_COLUMNS_DEF,
  parameter int FILTER_SLOTS = scbs_pkg::FILTER_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  scbs_sample_if.sink                     samples,
  scbs_blob_if.source                     blobs,
  input  logic                            cfg_we,
  input  logic [scbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scbs_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int LW = $clog2(MAX_COLUMNS + 1);
  localparam int MW = (CW > COL_OUT_W) ? CW : COL_OUT_W;

  // Configuration registers
  logic [FCOUNT_W-1:0] filter_count;
  logic [COLOR_W-1:0]  filter_color [FILTER_SLOTS];
  logic [ROWS_W-1:0]   columns_in_use;
  logic [ROWS_W-1:0]   rows_in_use;
  logic [RPR_W-1:0]    rows_per_radian;

  // Run state
  logic [CW-1:0]      column_index;
  logic               in_run;
  logic [COLOR_W-1:0] run_color;
  logic [CW-1:0]      run_start;
  logic [SUM_W-1:0]   range_sum;

  logic [CW-1:0]      column_index_next;
  logic               in_run_next;
  logic [COLOR_W-1:0] run_color_next;
  logic [CW-1:0]      run_start_next;
  logic [SUM_W-1:0]   range_sum_next;

  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_sat;
  logic [SUM_W-1:0]    close_sum;
  logic [CW-1:0]       col_prev;
  logic [CW-1:0]       col_inc;
  logic [CW-1:0]       last;
  logic                close;
  logic                pass;
  logic [FCOUNT_W-1:0] fc_eff;
  logic [LW-1:0]       len;
  logic                sample_acc;
  logic                launch;
  logic                busy;

  // Output register
  logic                 out_valid;
  logic                 out_blob;
  logic [COLOR_W-1:0]   out_color;
  logic [COL_OUT_W-1:0] out_left;
  logic [COL_OUT_W-1:0] out_right;
  logic [COL_OUT_W-1:0] out_top;
  logic [ROWS_W-1:0]    out_bottom;
  logic [MEAN_W-1:0]    out_mean;
  logic                 out_done;

  geo_cfg_t g_cfg;
  geo_res_t g_res;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_count    <= '0;
      columns_in_use  <= COLUMNS_RST;
      rows_in_use     <= ROWS_RST;
      rows_per_radian <= RPR_RST;
      for (int i = 0; i < FILTER_SLOTS; i++) begin
        filter_color[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FILTER_COUNT:    filter_count    <= cfg_data[FCOUNT_W-1:0];
        REG_COLUMNS_IN_USE:  columns_in_use  <= cfg_data[ROWS_W-1:0];
        REG_ROWS_IN_USE:     rows_in_use     <= cfg_data[ROWS_W-1:0];
        REG_ROWS_PER_RADIAN: rows_per_radian <= cfg_data[RPR_W-1:0];
        default: ;
      endcase
      for (int i = 0; i < FILTER_SLOTS; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_FILTER_COLOR_A) + CFG_IDX_W'(i)) begin
          filter_color[i] <= cfg_data;
        end
      end
    end
  end

  assign sample_acc = samples.valid && samples.ready;

  // Track runs and decide which sample closes one
  always_comb begin
    sum_add           = (SUM_W + 1)'(range_sum) + (SUM_W + 1)'(samples.sample_range_mm);
    sum_sat           = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    col_prev          = (column_index == '0) ? CW'(MAX_COLUMNS - 1) : column_index - 1'b1;
    col_inc           = (column_index == CW'(MAX_COLUMNS - 1)) ? '0 : column_index + 1'b1;
    in_run_next       = in_run;
    run_color_next    = run_color;
    run_start_next    = run_start;
    range_sum_next    = range_sum;
    close             = 1'b0;
    last              = column_index;
    if (in_run) begin
      if (samples.hit && (samples.sample_color == run_color)) begin
        range_sum_next = sum_sat;
        close          = samples.end_of_scan;
      end else begin
        close = 1'b1;
        last  = col_prev;
      end
    end else if (samples.hit) begin
      in_run_next    = 1'b1;
      run_color_next = samples.sample_color;
      run_start_next = column_index;
      range_sum_next = SUM_W'(samples.sample_range_mm);
      close          = samples.end_of_scan;
    end
    close_sum = range_sum_next;
    if (close) begin
      in_run_next = 1'b0;
    end
    if (samples.end_of_scan) begin
      column_index_next = '0;
      in_run_next       = 1'b0;
      range_sum_next    = '0;
    end else begin
      column_index_next = col_inc;
    end
  end

  // Color filter; an empty filter passes everything
  always_comb begin
    fc_eff = (filter_count > FCOUNT_W'(FILTER_SLOTS)) ? FCOUNT_W'(FILTER_SLOTS) : filter_count;
    pass   = (fc_eff == '0);
    for (int i = 0; i < FILTER_SLOTS; i++) begin
      if ((FCOUNT_W'(i) < fc_eff) && (filter_color[i] == run_color_next)) begin
        pass = 1'b1;
      end
    end
  end

  // Run length, wrapping at MAX_COLUMNS
  always_comb begin
    if (last >= run_start_next) begin
      len = LW'(last) - LW'(run_start_next) + 1'b1;
    end else begin
      len = LW'(MAX_COLUMNS) - LW'(run_start_next) + LW'(last) + 1'b1;
    end
  end

  assign launch = sample_acc && close && pass;

  assign g_cfg.rows_in_use     = rows_in_use;
  assign g_cfg.rows_per_radian = rows_per_radian;

  scbs_geom #(
    .LEN_W (LW)
  ) u_geom (
    .clk    (clk),
    .rst    (rst),
    .start  (launch),
    .sum_in (close_sum),
    .len_in (len),
    .cfg    (g_cfg),
    .res    (g_res)
  );

  // Advance run state, launch geometry, load the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      in_run       <= 1'b0;
      run_color    <= '0;
      run_start    <= '0;
      range_sum    <= '0;
      busy         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (sample_acc) begin
        column_index <= column_index_next;
        in_run       <= in_run_next;
        run_color    <= run_color_next;
        run_start    <= run_start_next;
        range_sum    <= range_sum_next;
      end
      // Raise the word when the engine finishes or an end-of-scan word is due
      if (g_res.done || (sample_acc && samples.end_of_scan && !launch)) begin
        out_valid <= 1'b1;
      end else if (blobs.valid && blobs.ready) begin
        out_valid <= 1'b0;
      end
      if (launch) begin
        busy      <= 1'b1;
        out_color <= run_color_next;
        out_left  <= COL_OUT_W'(MW'(columns_in_use) - MW'(1) - MW'(last));
        out_right <= COL_OUT_W'(MW'(columns_in_use) - MW'(1) - MW'(run_start_next));
        out_done  <= samples.end_of_scan;
      end else if (sample_acc && samples.end_of_scan) begin
        out_blob   <= 1'b0;
        out_color  <= '0;
        out_left   <= '0;
        out_right  <= '0;
        out_top    <= '0;
        out_bottom <= '0;
        out_mean   <= '0;
        out_done   <= 1'b1;
      end else if (g_res.done) begin
        busy       <= 1'b0;
        out_blob   <= 1'b1;
        out_top    <= g_res.top_row;
        out_bottom <= g_res.bottom_row;
        out_mean   <= g_res.mean;
      end
    end
  end

  // Hold off samples while a blob is in the engine or the word cannot leave
  assign samples.ready = !busy && (!out_valid || blobs.ready);

  assign blobs.valid         = out_valid;
  assign blobs.blob_valid    = out_blob;
  assign blobs.blob_color    = out_color;
  assign blobs.left_column   = out_left;
  assign blobs.right_column  = out_right;
  assign blobs.top_row       = out_top;
  assign blobs.bottom_row    = out_bottom;
  assign blobs.mean_range_mm = out_mean;
  assign blobs.scan_done     = out_done;

  `SCBS_ASSERT_NXT(a_launch_busy, clk, rst, launch, busy && !samples.ready, "launch did not stall input")
  `SCBS_ASSERT_IMP(a_done_room, clk, rst, g_res.done, busy && !out_valid, "blob with no room")
  `SCBS_ASSERT_NXT(a_eos_word, clk, rst, sample_acc && samples.end_of_scan && !launch, out_valid && out_done && !out_blob, "end of scan word missing")

endmodule

>>> rtl/scbs_geom.sv
`timescale 1ns / 1ps
`include "scanline_color_blob_segmenter_macros.svh"
// Blob geometry engine: mean range, arctangent series and row extent, all run
// on one shift-add accumulator and one restoring divider under a sequencer.
module scbs_geom #(
  parameter int LEN_W = 9
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [scbs_pkg::SUM_W-1:0] sum_in,
  input  logic [LEN_W-1:0]           len_in,
  input  scbs_pkg::geo_cfg_t         cfg,
  output scbs_pkg::geo_res_t         res
);
  import scbs_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_MEAN  = 15'h0002,
    S_SETUP = 15'h0004,
    S_PASS  = 15'h0008,
    S_SQX   = 15'h0010,
    S_SQY   = 15'h0020,
    S_PXY   = 15'h0040,
    S_DIVU  = 15'h0080,
    S_DIVZ  = 15'h0100,
    S_CHK   = 15'h0200,
    S_MULZ  = 15'h0400,
    S_MULK  = 15'h0800,
    S_DIVK  = 15'h1000,
    S_EXTM  = 15'h2000,
    S_ROWS  = 15'h4000
  } geo_state_t;

  geo_state_t        state;
  logic [5:0]        cnt;
  logic [60:0]       acc;
  logic [59:0]       mc;
  logic [39:0]       mb;
  logic [31:0]       rem;
  logic [47:0]       dq;
  logic [31:0]       dv;
  logic [39:0]       term;
  logic [39:0]       z;
  logic [41:0]       asum;
  logic [6:0]        nidx;
  logic [15:0]       xo;
  logic [15:0]       yo;
  logic [MEAN_W-1:0] mean;
  logic              second_pass;
  logic [31:0]       dd;
  logic [16:0]       yy;
  logic [9:0]        ext;

  logic        q40_mid;
  logic [60:0] acc_base;
  logic [59:0] mc_eff;
  logic [60:0] acc_add;
  logic [59:0] mc_adv;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        div_ge;
  logic [31:0] rem_adv;
  logic [47:0] dq_adv;
  logic        last_step;
  logic [7:0]  kmul;
  logic [7:0]  kdiv;
  logic [7:0]  half;
  logic [10:0] bsum;

  // Shared shift-add step; in the fraction product, drop 20 bits and restart
  // the multiplicand halfway through.
  always_comb begin
    q40_mid   = (state == S_MULZ) && (cnt == 6'd20);
    acc_base  = q40_mid ? {20'd0, acc[60:20]} : acc;
    mc_eff    = q40_mid ? {20'd0, term} : mc;
    acc_add   = acc_base + (mb[0] ? {1'b0, mc_eff} : 61'd0);
    mc_adv    = {mc_eff[58:0], 1'b0};
    last_step = (cnt == 6'd1);
    kmul      = 8'({nidx[5:0], 1'b0}) + 8'd2;
    kdiv      = 8'({nidx[5:0], 1'b1}) + 8'd2;
  end

  // Shared restoring divide step: one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem, dq[47]};
    rem_sub = rem_sh - {1'b0, dv};
    div_ge  = (rem_sh >= {1'b0, dv});
    rem_adv = div_ge ? rem_sub[31:0] : rem_sh[31:0];
    dq_adv  = {dq[46:0], div_ge};
  end

  // Row extent around the image center
  always_comb begin
    half = 8'(cfg.rows_in_use >> 1);
    bsum = 11'(half) + 11'(ext);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            dq    <= {sum_in, 24'd0};
            rem   <= '0;
            dv    <= 32'(len_in);
            cnt   <= 6'd24;
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          rem <= rem_adv;
          dq  <= dq_adv;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            mean  <= (dq_adv[23:16] != 8'd0) ? 16'hFFFF : dq_adv[15:0];
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          asum <= '0;
          if (mean >= HALF_HEIGHT_MM) begin
            xo          <= mean;
            yo          <= HALF_HEIGHT_MM;
            second_pass <= 1'b0;
          end else begin
            xo          <= 16'd1;
            yo          <= 16'd1;
            second_pass <= 1'b1;
          end
          state <= S_PASS;
        end
        S_PASS: begin
          acc   <= '0;
          mc    <= 60'(xo);
          mb    <= 40'(xo);
          cnt   <= 6'd16;
          state <= S_SQX;
        end
        S_SQX: begin
          acc <= acc_add;
          mc  <= mc_adv;
          mb  <= mb >> 1;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            dd    <= acc_add[31:0];
            acc   <= '0;
            mc    <= 60'(yo);
            mb    <= 40'(yo);
            cnt   <= 6'd16;
            state <= S_SQY;
          end
        end
        S_SQY: begin
          acc <= acc_add;
          mc  <= mc_adv;
          mb  <= mb >> 1;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            dd    <= dd + acc_add[31:0];
            yy    <= acc_add[16:0];
            acc   <= '0;
            mc    <= 60'(xo);
            mb    <= 40'(yo);
            cnt   <= 6'd16;
            state <= S_PXY;
          end
        end
        S_PXY: begin
          acc <= acc_add;
          mc  <= mc_adv;
          mb  <= mb >> 1;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            rem   <= acc_add[31:0];
            dq    <= '0;
            dv    <= dd;
            cnt   <= 6'd40;
            state <= S_DIVU;
          end
        end
        S_DIVU: begin
          rem <= rem_adv;
          dq  <= dq_adv;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            term  <= dq_adv[39:0];
            asum  <= asum + 42'(dq_adv[39:0]);
            rem   <= 32'(yy);
            dq    <= '0;
            cnt   <= 6'd40;
            state <= S_DIVZ;
          end
        end
        S_DIVZ: begin
          rem <= rem_adv;
          dq  <= dq_adv;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            z     <= dq_adv[39:0];
            nidx  <= '0;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if ((nidx == 7'd64) || (term == '0)) begin
            if (second_pass) begin
              second_pass <= 1'b0;
              xo          <= HALF_HEIGHT_MM + mean;
              yo          <= HALF_HEIGHT_MM - mean;
              state       <= S_PASS;
            end else begin
              acc   <= '0;
              mc    <= 60'(asum[41:26]);
              mb    <= 40'(cfg.rows_per_radian);
              cnt   <= 6'd16;
              state <= S_EXTM;
            end
          end else begin
            acc   <= '0;
            mc    <= 60'(term);
            mb    <= z;
            cnt   <= 6'd40;
            state <= S_MULZ;
          end
        end
        S_MULZ: begin
          acc <= acc_add;
          mc  <= mc_adv;
          mb  <= mb >> 1;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            acc   <= '0;
            mc    <= 60'(acc_add[59:20]);
            mb    <= 40'(kmul);
            cnt   <= 6'd8;
            state <= S_MULK;
          end
        end
        S_MULK: begin
          acc <= acc_add;
          mc  <= mc_adv;
          mb  <= mb >> 1;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            dq    <= acc_add[47:0];
            rem   <= '0;
            dv    <= 32'(kdiv);
            cnt   <= 6'd48;
            state <= S_DIVK;
          end
        end
        S_DIVK: begin
          rem <= rem_adv;
          dq  <= dq_adv;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            term  <= dq_adv[39:0];
            asum  <= asum + 42'(dq_adv[39:0]);
            nidx  <= nidx + 7'd1;
            state <= S_CHK;
          end
        end
        S_EXTM: begin
          acc <= acc_add;
          mc  <= mc_adv;
          mb  <= mb >> 1;
          cnt <= cnt - 6'd1;
          if (last_step) begin
            ext   <= acc_add[31:22];
            state <= S_ROWS;
          end
        end
        S_ROWS: begin
          res.done       <= 1'b1;
          res.mean       <= mean;
          res.top_row    <= (10'(half) > ext) ? 8'(10'(half) - ext) : 8'd0;
          res.bottom_row <= (bsum > 11'(cfg.rows_in_use)) ? cfg.rows_in_use : 9'(bsum);
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SCBS_ASSERT_IMP(a_start_idle, clk, rst, start, state == S_IDLE, "geometry start while busy")
  `SCBS_ASSERT_NXT(a_start_mean, clk, rst, start, state == S_MEAN, "geometry start not taken")
  `SCBS_ASSERT_IMP(a_rem_below, clk, rst, (state == S_MEAN || state == S_DIVU || state == S_DIVZ || state == S_DIVK), rem < dv, "divider remainder out of range")
  `SCBS_ASSERT_NXT(a_rows_done, clk, rst, state == S_ROWS, res.done && state == S_IDLE, "geometry result lost")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import scbs_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [COLOR_W-1:0] color;
    logic [RANGE_W-1:0] range_mm;
    logic               eos;
  } sample_t;

  typedef struct packed {
    logic                 blob_valid;
    logic [COLOR_W-1:0]   blob_color;
    logic [COL_OUT_W-1:0] left_column;
    logic [COL_OUT_W-1:0] right_column;
    logic [COL_OUT_W-1:0] top_row;
    logic [ROWS_W-1:0]    bottom_row;
    logic [MEAN_W-1:0]    mean_range_mm;
    logic                 scan_done;
  } blob_word_t;

  typedef struct packed {
    sample_t    smp;
    logic       typed;
    blob_word_t want;
  } step_row_t;

  localparam int NCOL = MAX_COLUMNS_DEF;
  localparam int NSLOT = FILTER_SLOTS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_FILTER_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scbs_sample_if smp_ch();
  scbs_blob_if blob_ch();

  scanline_color_blob_segmenter i_dut (
    .clk(clk), .rst(rst), .samples(smp_ch), .blobs(blob_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow of the block's registers and run state
  int unsigned m_fcount;
  logic [COLOR_W-1:0] m_fcolor [NSLOT];
  int unsigned m_cols, m_rows, m_rpr;
  int unsigned m_col, m_start, m_sum;
  logic m_in_run;
  logic [COLOR_W-1:0] m_run_color;

  blob_word_t blob_q[$];
  bit failed = 1'b0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int accepted = 0;
  logic [COLOR_W-1:0] palette [6];

  function automatic longint unsigned div_q40(longint unsigned n, longint unsigned d);
    longint unsigned hi, rem, lo;
    if (d == 0) return 0;
    hi = (n << 20) / d;
    rem = (n << 20) % d;
    lo = (rem << 20) / d;
    return (hi << 20) + lo;
  endfunction

  function automatic longint unsigned mul_q40(longint unsigned a, longint unsigned b);
    longint unsigned p;
    p = a * (b >> 20) + ((a * (b & 64'hFFFFF)) >> 20);
    return p >> 20;
  endfunction

  // Euler series arctangent of y/x, Q.40
  function automatic longint unsigned arctan_q40(longint unsigned x, longint unsigned y);
    longint unsigned d, u, z, term, acc;
    d = x * x + y * y;
    u = div_q40(x * y, d);
    z = div_q40(y * y, d);
    term = u;
    acc = u;
    for (int n = 0; n < 64 && term != 0; n++) begin
      term = mul_q40(term, z);
      term = term * (2 * n + 2) / (2 * n + 3);
      acc += term;
    end
    return acc;
  endfunction

  function automatic int unsigned half_height_angle(int unsigned r);
    longint unsigned a;
    if (r >= 300) a = arctan_q40(r, 300);
    else a = arctan_q40(1, 1) + arctan_q40(300 + r, 300 - r);
    return int'(a >> 26);
  endfunction

  function automatic bit color_accepted(logic [COLOR_W-1:0] c);
    int unsigned n;
    n = (m_fcount > NSLOT) ? NSLOT : m_fcount;
    if (n == 0) return 1'b1;
    for (int i = 0; i < n; i++) if (m_fcolor[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  // Close the open run ending at column last; return 1 with the blob if it passes
  function automatic bit close_blob(int unsigned last, output blob_word_t w);
    int unsigned len, mean, ext, half, top, bottom;
    w = '0;
    m_in_run = 1'b0;
    if (!color_accepted(m_run_color)) return 1'b0;
    len = (last + NCOL - m_start) % NCOL + 1;
    mean = m_sum / len;
    if (mean > 65535) mean = 65535;
    ext = int'((longint'(half_height_angle(mean)) * m_rpr) >> 22);
    half = m_rows / 2;
    top = (half > ext) ? half - ext : 0;
    bottom = half + ext;
    if (bottom > m_rows) bottom = m_rows;
    w.blob_valid = 1'b1;
    w.blob_color = m_run_color;
    w.left_column = 8'(m_cols - 1 - last);
    w.right_column = 8'(m_cols - 1 - m_start);
    w.top_row = 8'(top);
    w.bottom_row = 9'(bottom);
    w.mean_range_mm = 16'(mean);
    return 1'b1;
  endfunction

  function automatic bit predict_blob(sample_t s, output blob_word_t w);
    int unsigned c;
    bit emit;
    c = m_col;
    emit = 1'b0;
    w = '0;
    if (m_in_run) begin
      if (s.hit && s.color == m_run_color) begin
        m_sum += s.range_mm;
        if (m_sum > SUM_MAX) m_sum = SUM_MAX;
        if (s.eos) emit = close_blob(c, w);
      end else begin
        emit = close_blob((c + NCOL - 1) % NCOL, w);
      end
    end else if (s.hit) begin
      m_in_run = 1'b1;
      m_run_color = s.color;
      m_start = c;
      m_sum = s.range_mm;
      if (s.eos) emit = close_blob(c, w);
    end
    if (s.eos) begin
      m_col = 0;
      m_in_run = 1'b0;
      m_sum = 0;
      w.scan_done = 1'b1;
      return 1'b1;
    end
    m_col = (c + 1) % NCOL;
    return emit;
  endfunction

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FILTER_COUNT:    m_fcount = val & 7;
      REG_FILTER_COLOR_A:  m_fcolor[0] = COLOR_W'(val);
      REG_FILTER_COLOR_B:  m_fcolor[1] = COLOR_W'(val);
      REG_FILTER_COLOR_C:  m_fcolor[2] = COLOR_W'(val);
      REG_FILTER_COLOR_D:  m_fcolor[3] = COLOR_W'(val);
      REG_COLUMNS_IN_USE:  m_cols = val & 9'h1FF;
      REG_ROWS_IN_USE:     m_rows = val & 9'h1FF;
      REG_ROWS_PER_RADIAN: m_rpr = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  // Drive one sample word; called just after a falling edge, returns once taken
  task automatic send_sample(sample_t s, bit typed, blob_word_t want);
    blob_word_t w;
    while ($urandom_range(99) < snd_idle_pct) begin
      smp_ch.valid = 1'b0;
      @(negedge clk);
    end
    smp_ch.valid = 1'b1;
    smp_ch.hit = s.hit;
    smp_ch.sample_color = s.color;
    smp_ch.sample_range_mm = s.range_mm;
    smp_ch.end_of_scan = s.eos;
    do @(posedge clk); while (!smp_ch.ready);
    if (predict_blob(s, w)) blob_q.insert(blob_q.size(), typed ? want : w);
    accepted++;
    @(negedge clk);
  endtask

  task automatic go_idle();
    smp_ch.valid = 1'b0;
    wait (blob_q.size() == 0);
    repeat (13000) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic sample_t rand_sample(logic [COLOR_W-1:0] c, bit hit, bit eos);
    sample_t s;
    s.hit = hit;
    s.color = c;
    s.range_mm = ($urandom_range(3) == 0) ? RANGE_W'($urandom_range(600))
                                          : RANGE_W'($urandom);
    s.eos = eos;
    return s;
  endfunction

  // One scan line: runs of palette colors split by misses, with some noise
  task automatic send_line(int unsigned len);
    sample_t s;
    logic [COLOR_W-1:0] c;
    int unsigned n, k;
    n = 0;
    while (n < len) begin
      c = palette[$urandom_range(5)];
      k = $urandom_range(6, 1);
      for (int i = 0; i < k && n < len; i++) begin
        if ($urandom_range(9) == 0) s = rand_sample(COLOR_W'($urandom), 1'($urandom), 1'b0);
        else s = rand_sample(c, 1'b1, 1'b0);
        n++;
        s.eos = (n == len);
        send_sample(s, 1'b0, '0);
      end
      k = $urandom_range(2);
      for (int i = 0; i < k && n < len; i++) begin
        s = rand_sample(COLOR_W'($urandom), 1'b0, 1'b0);
        n++;
        s.eos = (n == len);
        send_sample(s, 1'b0, '0);
      end
    end
  endtask

  // One long run that wraps the column counter and saturates the range sum
  task automatic send_long_run();
    sample_t s;
    s.hit = 1'b1;
    s.color = palette[0];
    s.eos = 1'b0;
    for (int i = 0; i < 300; i++) begin
      s.range_mm = RANGE_W'($urandom_range(65535, 60000));
      s.eos = (i == 299);
      send_sample(s, 1'b0, '0);
    end
  endtask

  step_row_t directed [17] = '{
    '{'{1'b0, 24'h000000, 16'd0,     1'b1}, 1'b1, '{1'b0, '0, '0, '0, '0, '0, '0, 1'b1}},
    '{'{1'b1, 24'hFFFFFF, 16'd0,     1'b0}, 1'b0, '0},
    '{'{1'b1, 24'hFFFFFF, 16'hFFFF,  1'b0}, 1'b0, '0},
    '{'{1'b0, 24'h123456, 16'd1234,  1'b0}, 1'b0, '0},
    '{'{1'b1, 24'h000000, 16'd300,   1'b1}, 1'b0, '0},
    '{'{1'b1, 24'hABCDEF, 16'd299,   1'b0}, 1'b0, '0},
    '{'{1'b1, 24'hABCDEF, 16'd301,   1'b0}, 1'b0, '0},
    '{'{1'b1, 24'h555555, 16'd5000,  1'b0}, 1'b0, '0},
    '{'{1'b1, 24'h555555, 16'd5000,  1'b0}, 1'b0, '0},
    '{'{1'b1, 24'h555555, 16'd7000,  1'b1}, 1'b0, '0},
    '{'{1'b1, 24'h800000, 16'd1,     1'b0}, 1'b0, '0},
    '{'{1'b0, 24'h000000, 16'd0,     1'b1}, 1'b0, '0},
    '{'{1'b1, 24'h00FF00, 16'hFFFF,  1'b1}, 1'b0, '0},
    '{'{1'b0, 24'hFFFFFF, 16'hFFFF,  1'b0}, 1'b0, '0},
    '{'{1'b1, 24'h7F7F7F, 16'd150,   1'b0}, 1'b0, '0},
    '{'{1'b1, 24'h7F7F7F, 16'd20000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 24'h000000, 16'd0,     1'b1}, 1'b0, '0}
  };

  // Result side: stall at random, check every word against the oldest expectation
  always @(negedge clk) blob_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);

  always @(posedge clk) begin
    blob_word_t got, want;
    if (!rst && blob_ch.valid && blob_ch.ready) begin
      got = '{blob_ch.blob_valid, blob_ch.blob_color, blob_ch.left_column,
              blob_ch.right_column, blob_ch.top_row, blob_ch.bottom_row,
              blob_ch.mean_range_mm, blob_ch.scan_done};
      if (blob_q.size() == 0) begin
        $display("%0t: unexpected blob word %h", $realtime, got);
        failed = 1'b1;
      end else begin
        want = blob_q.pop_front();
        if (got.blob_valid !== want.blob_valid ||
            got.blob_color !== want.blob_color ||
            got.left_column !== want.left_column ||
            got.right_column !== want.right_column ||
            got.top_row !== want.top_row ||
            got.bottom_row !== want.bottom_row ||
            got.mean_range_mm !== want.mean_range_mm ||
            got.scan_done !== want.scan_done) begin
          $display("%0t: blob mismatch expected v=%b c=%h l=%0d r=%0d t=%0d b=%0d m=%0d d=%b",
                   $realtime, want.blob_valid, want.blob_color, want.left_column,
                   want.right_column, want.top_row, want.bottom_row,
                   want.mean_range_mm, want.scan_done);
          $display("%0t:               actual   v=%b c=%h l=%0d r=%0d t=%0d b=%0d m=%0d d=%b",
                   $realtime, got.blob_valid, got.blob_color, got.left_column,
                   got.right_column, got.top_row, got.bottom_row,
                   got.mean_range_mm, got.scan_done);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #1500ms;
    $display("** scanline_color_blob_segmenter: FAILED **");
    $finish;
  end

  initial begin
    int target;
    smp_ch.valid = 1'b0;
    smp_ch.hit = 1'b0;
    smp_ch.sample_color = '0;
    smp_ch.sample_range_mm = '0;
    smp_ch.end_of_scan = 1'b0;
    blob_ch.ready = 1'b0;
    m_fcount = 0;
    foreach (m_fcolor[i]) m_fcolor[i] = '0;
    m_cols = COLUMNS_RST;
    m_rows = ROWS_RST;
    m_rpr = RPR_RST;
    m_col = 0;
    m_start = 0;
    m_sum = 0;
    m_in_run = 1'b0;
    m_run_color = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows at reset settings
    foreach (directed[i]) send_sample(directed[i].smp, directed[i].typed, directed[i].want);
    go_idle();

    // Random phases, each with its own settings and idling
    for (int ph = 0; ph < 6; ph++) begin
      foreach (palette[i]) palette[i] = COLOR_W'($urandom);
      if (ph == 2) begin
        palette[1] = '0;
        palette[2] = '1;
      end
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 77; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 77; end
        3: begin snd_idle_pct = 28; rcv_stall_pct = 28; end
        4: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        default: begin snd_idle_pct = 28; rcv_stall_pct = 77; end
      endcase
      case (ph)
        0: write_reg(REG_FILTER_COUNT, 0);
        1: write_reg(REG_FILTER_COUNT, 4);
        2: write_reg(REG_FILTER_COUNT, 7);
        3: write_reg(REG_FILTER_COUNT, 1);
        4: write_reg(REG_FILTER_COUNT, 2);
        default: write_reg(REG_FILTER_COUNT, 3);
      endcase
      write_reg(REG_FILTER_COLOR_A, palette[0]);
      write_reg(REG_FILTER_COLOR_B, palette[1]);
      write_reg(REG_FILTER_COLOR_C, (ph == 2) ? palette[2] : COLOR_W'($urandom));
      write_reg(REG_FILTER_COLOR_D, palette[3]);
      case (ph)
        0: begin
          write_reg(REG_COLUMNS_IN_USE, 80);
          write_reg(REG_ROWS_IN_USE, 60);
          write_reg(REG_ROWS_PER_RADIAN, 14668);
        end
        1: begin
          write_reg(REG_COLUMNS_IN_USE, 256);
          write_reg(REG_ROWS_IN_USE, 256);
          write_reg(REG_ROWS_PER_RADIAN, 65535);
        end
        2: begin
          write_reg(REG_COLUMNS_IN_USE, 1);
          write_reg(REG_ROWS_IN_USE, 1);
          write_reg(REG_ROWS_PER_RADIAN, 0);
        end
        3: begin
          write_reg(REG_COLUMNS_IN_USE, 200);
          write_reg(REG_ROWS_IN_USE, 511);
          write_reg(REG_ROWS_PER_RADIAN, 1000);
        end
        4: begin
          write_reg(REG_COLUMNS_IN_USE, 511);
          write_reg(REG_ROWS_IN_USE, 2);
          write_reg(REG_ROWS_PER_RADIAN, 40000);
        end
        default: begin
          write_reg(REG_COLUMNS_IN_USE, $urandom_range(256, 1));
          write_reg(REG_ROWS_IN_USE, $urandom_range(256, 1));
          write_reg(REG_ROWS_PER_RADIAN, $urandom_range(65535));
        end
      endcase
      target = accepted + 75;
      if (ph == 1 || ph == 4) send_long_run();
      while (accepted < target) send_line($urandom_range(40, 1));
      go_idle();
    end

    rcv_stall_pct = 0;
    if (failed) begin
      $display("** scanline_color_blob_segmenter: FAILED **");
    end else begin
      $display("** scanline_color_blob_segmenter: PASSED **");
    end
    $finish;
  end

endmodule
